// ===== rtl/pip_pkg.sv =====
// shared constants, types and helpers for the point-in-polygon test core
// no dependencies
`default_nettype none

package pip_pkg;

  localparam int FIELD_WIDTH = 32;
  localparam int COORD_WIDTH = 32;
  localparam int DIFF_WIDTH = COORD_WIDTH + 1;
  localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
  localparam int INDEX_WIDTH = 1;

  localparam logic [1:0] MIN_EDGES = 2'd3;

  localparam logic [INDEX_WIDTH-1:0] REG_POINT_X = 1'd0;
  localparam logic [INDEX_WIDTH-1:0] REG_POINT_Y = 1'd1;

  typedef logic signed [DIFF_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  // per-edge terms handed from the arithmetic stage to the state update
  typedef struct packed {
    logic  straddle;
    logic  div_pos;
    logic  hline_hit;
    prod_t prod_a;
    prod_t prod_b;
  } edge_eval_t;

  // low COORD_WIDTH bits, sign-extended by one bit for exact differences
  function automatic coord_t sext_coord(input logic [FIELD_WIDTH-1:0] v);
    return {v[COORD_WIDTH-1], v[COORD_WIDTH-1:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pip_edge_eval.sv =====
// per-edge arithmetic: straddle test, horizontal hit and the two cross products
// depends on pip_pkg
`default_nettype none

module pip_edge_eval (
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] point_x,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] point_y,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] start_x,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] start_y,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] end_x,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] end_y,
  output pip_pkg::edge_eval_t                  eval
);

  pip_pkg::coord_t px, py, x0, y0, x1, y1;
  pip_pkg::coord_t d, dy, dx, rx;

  assign px = pip_pkg::sext_coord(point_x);
  assign py = pip_pkg::sext_coord(point_y);
  assign x0 = pip_pkg::sext_coord(start_x);
  assign y0 = pip_pkg::sext_coord(start_y);
  assign x1 = pip_pkg::sext_coord(end_x);
  assign y1 = pip_pkg::sext_coord(end_y);

  // operands stay inside COORD_WIDTH, so every difference is exact
  assign d  = y0 - y1;
  assign dy = py - y1;
  assign dx = x0 - x1;
  assign rx = px - x1;

  always_comb begin
    eval.straddle  = ((py > y1) && (py <= y0)) || ((py > y0) && (py <= y1));
    eval.div_pos   = (d > 0);
    eval.hline_hit = (py == y0) && (py == y1) &&
                     (((px >= x0) && (px <= x1)) || ((px >= x1) && (px <= x0)));
    eval.prod_a    = pip_pkg::PROD_WIDTH'(dy) * pip_pkg::PROD_WIDTH'(dx);
    eval.prod_b    = pip_pkg::PROD_WIDTH'(rx) * pip_pkg::PROD_WIDTH'(d);
  end

endmodule

`default_nettype wire

// ===== rtl/point_in_polygon_test_core.sv =====
// even-odd ray-casting point-in-polygon test, one polygon edge per request
// a verdict reaches the output register once its last edge has passed the
// input and product registers; throughput: one edge per cycle while in_stall
// is low; each register holds one request and they advance independently
// reset: rst (synchronous) clears point registers, parity, boundary flag,
// edge count and all valid bits
// depends on pip_pkg and pip_edge_eval
`default_nettype none

module point_in_polygon_test_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [pip_pkg::INDEX_WIDTH-1:0] wr_index,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] start_x,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] start_y,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] end_x,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] end_y,
  input  wire logic                            last_edge,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 inside_res,
  output logic                                 on_boundary,
  output logic                                 too_few_edges
);

  logic [pip_pkg::FIELD_WIDTH-1:0] point_x, point_y;

  // input stage
  logic                            s1_valid;
  logic [pip_pkg::FIELD_WIDTH-1:0] s1_start_x, s1_start_y, s1_end_x, s1_end_y;
  logic                            s1_last;

  // product stage
  logic                s2_valid;
  logic                s2_last;
  pip_pkg::edge_eval_t s2_eval;
  pip_pkg::edge_eval_t eval;

  // polygon state
  logic       crossing_parity, crossing_parity_next;
  logic       boundary_hit, boundary_hit_next;
  logic [1:0] edges_seen, edges_seen_next;
  logic       left;

  logic out_free, s2_done, s2_load, s1_load;

  pip_edge_eval u_eval (
    .point_x (point_x),
    .point_y (point_y),
    .start_x (s1_start_x),
    .start_y (s1_start_y),
    .end_x   (s1_end_x),
    .end_y   (s1_end_y),
    .eval    (eval)
  );

  // only a last edge needs the output register
  assign out_free = !out_valid || !out_stall;
  assign s2_done  = s2_valid && (!s2_last || out_free);
  assign s2_load  = !s2_valid || s2_done;
  assign s1_load  = !s1_valid || s2_load;
  assign in_stall = !s1_load;

  // sign-adjusted cross multiplication instead of the crossing division
  assign left = s2_eval.div_pos ? (s2_eval.prod_a < s2_eval.prod_b)
                                : (s2_eval.prod_b < s2_eval.prod_a);

  always_comb begin
    crossing_parity_next = crossing_parity ^ (s2_eval.straddle && left);
    boundary_hit_next    = boundary_hit | s2_eval.hline_hit;
    edges_seen_next      = (edges_seen == pip_pkg::MIN_EDGES) ? edges_seen
                                                              : edges_seen + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_x <= '0;
      point_y <= '0;
    end else if (wr_en) begin
      case (wr_index)
        pip_pkg::REG_POINT_X: point_x <= wr_data;
        pip_pkg::REG_POINT_Y: point_y <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
    if (s1_load && in_valid) begin
      s1_start_x <= start_x;
      s1_start_y <= start_y;
      s1_end_x   <= end_x;
      s1_end_y   <= end_y;
      s1_last    <= last_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
    if (s2_load && s1_valid) begin
      s2_eval <= eval;
      s2_last <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_parity <= 1'b0;
      boundary_hit    <= 1'b0;
      edges_seen      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (s2_done && s2_last) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (s2_done) begin
        if (s2_last) begin
          crossing_parity <= 1'b0;
          boundary_hit    <= 1'b0;
          edges_seen      <= '0;
        end else begin
          crossing_parity <= crossing_parity_next;
          boundary_hit    <= boundary_hit_next;
          edges_seen      <= edges_seen_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_done && s2_last) begin
      inside_res    <= crossing_parity_next | boundary_hit_next;
      on_boundary   <= boundary_hit_next;
      too_few_edges <= (edges_seen_next < pip_pkg::MIN_EDGES);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pip_checker.sv =====
// port-level checks for point_in_polygon_test_core, attached by bind
// depends on point_in_polygon_test_core
`default_nettype none

module pip_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic inside_res,
  input wire logic on_boundary,
  input wire logic too_few_edges
);

  // reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a boundary hit forces inside
  a_boundary_inside: assert property (@(posedge clk) disable iff (rst)
    (out_valid && on_boundary) |-> inside_res)
    else $error("on_boundary without inside_res");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      ($stable(inside_res) && $stable(on_boundary) && $stable(too_few_edges)))
    else $error("stalled result changed");

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (.*);

`default_nettype wire

// ===== dv/pip_result_checker.sv =====
`timescale 1ns / 100ps
// watches the edge, result and register ports of point_in_polygon_test_core,
// predicts each polygon verdict by exact ray casting and compares the results
// depends on pip_pkg
module pip_result_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [pip_pkg::INDEX_WIDTH-1:0] wr_index,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] wr_data,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] start_x,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] start_y,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] end_x,
  input  wire logic [pip_pkg::FIELD_WIDTH-1:0] end_y,
  input  wire logic                            last_edge,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire logic                            inside_res,
  input  wire logic                            on_boundary,
  input  wire logic                            too_few_edges,
  output int                                   verdicts_due,
  output int                                   bad_verdicts
);

  localparam int MAX_REPORTS = 10;

  // wide enough for the exact product of two coordinate differences
  typedef logic signed [71:0] wide_t;

  typedef struct packed {
    logic in_poly;
    logic boundary;
    logic few;
  } verdict_t;

  verdict_t                          verdict_q[$];
  logic [pip_pkg::FIELD_WIDTH-1:0]   query_x = '0;
  logic [pip_pkg::FIELD_WIDTH-1:0]   query_y = '0;
  logic                              parity = 1'b0;
  logic                              boundary = 1'b0;
  logic [1:0]                        edge_count = '0;

  function automatic wide_t to_coord(input logic [pip_pkg::FIELD_WIDTH-1:0] v);
    logic signed [pip_pkg::COORD_WIDTH-1:0] c;
    c = v[pip_pkg::COORD_WIDTH-1:0];
    return wide_t'(c);
  endfunction

  task automatic ray_cast_edge(input logic [pip_pkg::FIELD_WIDTH-1:0] sx, sy, ex, ey,
                               input logic last);
    wide_t px, py, x0, y0, x1, y1, d, dy, dx, rx;
    logic  left;
    px = to_coord(query_x);
    py = to_coord(query_y);
    x0 = to_coord(sx);
    y0 = to_coord(sy);
    x1 = to_coord(ex);
    y1 = to_coord(ey);
    if (edge_count < pip_pkg::MIN_EDGES) edge_count++;
    // half-open straddle test, so a horizontal edge never counts
    if ((py > y1 && py <= y0) || (py > y0 && py <= y1)) begin
      d  = y0 - y1;
      dy = py - y1;
      dx = x0 - x1;
      rx = px - x1;
      // crossing strictly left of the point, division folded into the compare
      left = (d > 0) ? (dy * dx < rx * d) : (rx * d < dy * dx);
      if (left) parity = ~parity;
    end
    if (py == y0 && py == y1) begin
      if ((px >= x0 && px <= x1) || (px >= x1 && px <= x0)) boundary = 1'b1;
    end
    if (last) begin
      verdict_q.push_back('{parity | boundary, boundary,
                            edge_count < pip_pkg::MIN_EDGES});
      parity     = 1'b0;
      boundary   = 1'b0;
      edge_count = '0;
    end
  endtask

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst) begin
      query_x    = '0;
      query_y    = '0;
      parity     = 1'b0;
      boundary   = 1'b0;
      edge_count = '0;
      verdict_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{inside_res, on_boundary, too_few_edges};
        if (verdict_q.size() == 0) begin
          bad_verdicts++;
          if (bad_verdicts <= MAX_REPORTS)
            $display("%0t: unexpected result inside=%0b boundary=%0b few=%0b",
                     $time, got.in_poly, got.boundary, got.few);
        end else begin
          want = verdict_q.pop_front();
          if (got.in_poly !== want.in_poly || got.boundary !== want.boundary ||
              got.few !== want.few) begin
            bad_verdicts++;
            if (bad_verdicts <= MAX_REPORTS)
              $display({"%0t: result mismatch: expected inside=%0b boundary=%0b few=%0b,",
                        " got inside=%0b boundary=%0b few=%0b"}, $time, want.in_poly,
                       want.boundary, want.few, got.in_poly, got.boundary, got.few);
          end
        end
      end
      if (wr_en) begin
        case (wr_index)
          pip_pkg::REG_POINT_X: query_x = wr_data;
          pip_pkg::REG_POINT_Y: query_y = wr_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        ray_cast_edge(start_x, start_y, end_x, end_y, last_edge);
    end
    verdicts_due <= verdict_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// top of the point_in_polygon_test_core bench: clock, reset, edge stimulus,
// receiver stalls and the verdict; depends on pip_pkg, point_in_polygon_test_core and pip_result_checker
module testbench;

  localparam logic [pip_pkg::FIELD_WIDTH-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [pip_pkg::FIELD_WIDTH-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [pip_pkg::FIELD_WIDTH-1:0] ONE = 32'h0001_0000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES = 8;
  localparam int EDGES_PER_PHASE = 150;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            wr_en = 1'b0;
  logic [pip_pkg::INDEX_WIDTH-1:0] wr_index = '0;
  logic [pip_pkg::FIELD_WIDTH-1:0] wr_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [pip_pkg::FIELD_WIDTH-1:0] start_x = '0;
  logic [pip_pkg::FIELD_WIDTH-1:0] start_y = '0;
  logic [pip_pkg::FIELD_WIDTH-1:0] end_x = '0;
  logic [pip_pkg::FIELD_WIDTH-1:0] end_y = '0;
  logic                            last_edge = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            inside_res;
  logic                            on_boundary;
  logic                            too_few_edges;
  int                              verdicts_due;
  int                              bad_verdicts;

  int                              tx_idle_pct = 0;
  int                              rx_idle_pct = 0;
  logic                            hold_req = 1'b0;
  logic                            hold_ack = 1'b0;
  int                              hold_left = 0;
  int                              edges_sent = 0;
  logic [pip_pkg::FIELD_WIDTH-1:0] pt_x = '0;
  logic [pip_pkg::FIELD_WIDTH-1:0] pt_y = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  point_in_polygon_test_core i_dut (.*);

  pip_result_checker i_checker (.*);

  // receiver: random stalls, or one long hold-off when requested
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  function automatic logic [pip_pkg::FIELD_WIDTH-1:0] q16(input int k);
    return pip_pkg::FIELD_WIDTH'(k) << 16;
  endfunction

  // coordinate near a base value, or an extreme or fully random one; tight spreads hit exact equalities
  function automatic logic [pip_pkg::FIELD_WIDTH-1:0] near(
      input logic [pip_pkg::FIELD_WIDTH-1:0] base, input int spread);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
    case (spread)
      0: return base + pip_pkg::FIELD_WIDTH'($urandom_range(0, 4)) - 32'd2;
      1: return base + (pip_pkg::FIELD_WIDTH'($urandom_range(0, 8)) - 32'd4) * ONE;
      2: return base + pip_pkg::FIELD_WIDTH'($urandom_range(0, 2097151)) - 32'd1048576;
      default: return $urandom();
    endcase
  endfunction

  task automatic set_idling(input int tx, input int rx);
    tx_idle_pct = tx;
    rx_idle_pct <= rx;
  endtask

  task automatic send_edge(input logic [pip_pkg::FIELD_WIDTH-1:0] sx, sy, ex, ey,
                           input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    start_x   <= sx;
    start_y   <= sy;
    end_x     <= ex;
    end_y     <= ey;
    last_edge <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    edges_sent++;
  endtask

  // stop offering, let every pending verdict arrive and the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_point(input logic [pip_pkg::FIELD_WIDTH-1:0] x, y);
    wr_en    <= 1'b1;
    wr_index <= pip_pkg::REG_POINT_X;
    wr_data  <= x;
    @(posedge clk);
    wr_index <= pip_pkg::REG_POINT_Y;
    wr_data  <= y;
    @(posedge clk);
    wr_en <= 1'b0;
    pt_x = x;
    pt_y = y;
  endtask

  // closed polygon around the query point, or a broken run of loose edges
  task automatic send_polygon(input int n, input logic broken);
    logic [pip_pkg::FIELD_WIDTH-1:0] vx [8];
    logic [pip_pkg::FIELD_WIDTH-1:0] vy [8];
    int                              spread;
    int                              i;
    spread = $urandom_range(0, 3);
    for (i = 0; i < n; i++) begin
      vx[i] = near(pt_x, spread);
      vy[i] = near(pt_y, spread);
    end
    for (i = 0; i < n; i++) begin
      if (broken)
        send_edge(near(pt_x, spread), near(pt_y, spread), vx[i], vy[i],
                  (i == n - 1) || ($urandom_range(0, 3) == 0));
      else
        send_edge(vx[i], vy[i], vx[(i + 1) % n], vy[(i + 1) % n], i == n - 1);
    end
  endtask

  task automatic send_random_polygon();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
    send_polygon(n, $urandom_range(0, 99) < 15);
  endtask

  initial begin
    int                              phase;
    int                              goal;
    logic [pip_pkg::FIELD_WIDTH-1:0] qx;
    logic [pip_pkg::FIELD_WIDTH-1:0] qy;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_idling(31, 88);
    write_point('0, '0);

    // square around the point
    send_edge(q16(-1), q16(-1), q16(1), q16(-1), 1'b0);
    send_edge(q16(1), q16(-1), q16(1), q16(1), 1'b0);
    send_edge(q16(1), q16(1), q16(-1), q16(1), 1'b0);
    send_edge(q16(-1), q16(1), q16(-1), q16(-1), 1'b1);
    // point on a horizontal edge
    send_edge(q16(-1), '0, q16(1), '0, 1'b0);
    send_edge(q16(1), '0, '0, q16(1), 1'b0);
    send_edge('0, q16(1), q16(-1), '0, 1'b1);
    // crossing exactly at the point does not count
    send_edge('0, q16(-1), '0, q16(1), 1'b0);
    send_edge('0, q16(1), q16(5), q16(5), 1'b0);
    send_edge(q16(5), q16(5), '0, q16(-1), 1'b1);
    // single edge, then a zero-length edge on the point
    send_edge(q16(-3), q16(-1), q16(-2), q16(2), 1'b1);
    send_edge('0, '0, '0, '0, 1'b1);
    // polygon below MIN_EDGES, sent as an edge and its reverse
    send_edge(q16(-1), q16(-1), q16(-1), q16(1), 1'b0);
    send_edge(q16(-1), q16(1), q16(-1), q16(-1), 1'b1);
    // full-range triangle
    send_edge(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
    send_edge(COORD_MAX, COORD_MIN, '0, COORD_MAX, 1'b0);
    send_edge('0, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
    // diamond with vertices exactly at the point's y
    send_edge(q16(-2), '0, '0, q16(-2), 1'b0);
    send_edge('0, q16(-2), q16(2), '0, 1'b0);
    send_edge(q16(2), '0, '0, q16(2), 1'b0);
    send_edge('0, q16(2), q16(-2), '0, 1'b1);
    drain();

    // long receiver hold-off while edges keep coming
    set_idling(0, 88);
    hold_req <= ~hold_req;
    goal = edges_sent + 40;
    while (edges_sent < goal) send_random_polygon();
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < 3) set_idling(31, 88);
      else if (phase < 6) set_idling(88, 31);
      else set_idling(0, 0);
      case (phase)
        0: begin qx = COORD_MAX; qy = COORD_MAX; end
        1: begin qx = COORD_MIN; qy = COORD_MIN; end
        2: begin qx = COORD_MIN; qy = COORD_MAX; end
        3: begin qx = COORD_MAX; qy = COORD_MIN; end
        default: begin qx = $urandom(); qy = $urandom(); end
      endcase
      write_point(qx, qy);
      goal = edges_sent + EDGES_PER_PHASE;
      while (edges_sent < goal) send_random_polygon();
      drain();
    end

    if (bad_verdicts == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pip_pkg.sv
rtl/pip_edge_eval.sv
rtl/point_in_polygon_test_core.sv
rtl/pip_checker.sv
dv/pip_result_checker.sv
dv/testbench.sv
